/* hdl/rlid_pkg.sv */
// shared types and constants for the ring list insert/delete core
`timescale 1ns / 1ps
package rlid_pkg;

  // default ring depth
  localparam int DEPTH_DEF = 16;
  // width used for index and count compares, covers depth up to 256
  localparam int CMP_W = 9;
  localparam int VAL_W = 32;
  localparam int IDX_W = 8;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DEL_RD,
    S_SHIFT,
    S_DRAIN,
    S_INS_WR,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    ptr_ins;
    logic    ptr_del;
    logic    rd;
    logic    shift;
    logic    write_value;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t code;
    logic    out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_del;
    logic full;
    logic empty;
    logic one;
    logic idx_bad;
    logic idx_last;
    logic last_rd;
  } stat_t;

endpackage

/* hdl/rlid_dpath.sv */
// datapath: entry memory, entry count, shift pointer and result registers
`timescale 1ns / 1ps
module rlid_dpath #(
  parameter int DEPTH = rlid_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rlid_pkg::ctl_t                     ctl,
  output rlid_pkg::stat_t                    st,
  input  logic                               command,
  input  logic signed [rlid_pkg::VAL_W-1:0]  value,
  input  logic [rlid_pkg::IDX_W-1:0]         index,
  output logic signed [rlid_pkg::VAL_W-1:0]  removed_value,
  output logic [1:0]                         status,
  output logic [rlid_pkg::CNT_OUT_W-1:0]     entry_count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = rlid_pkg::CMP_W;

  logic signed [rlid_pkg::VAL_W-1:0] mem [DEPTH];

  logic                              op;
  logic signed [rlid_pkg::VAL_W-1:0] val;
  logic [rlid_pkg::IDX_W-1:0]        idx;
  logic [CW-1:0]                     count;
  logic [AW-1:0]                     ptr;
  logic signed [rlid_pkg::VAL_W-1:0] rdata;
  logic [AW-1:0]                     dest;
  logic                              pend;
  logic                              cap;
  logic signed [rlid_pkg::VAL_W-1:0] removed;
  rlid_pkg::status_t                 res_status;

  logic [CMPW-1:0]                   idx_w;
  logic [CMPW-1:0]                   cnt_w;
  logic [CMPW-1:0]                   ptr_w;
  logic [CW+rlid_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [rlid_pkg::VAL_W-1:0] wdata;

  assign idx_w   = CMPW'(idx);
  assign cnt_w   = CMPW'(count);
  assign ptr_w   = CMPW'(ptr);
  assign cnt_ext = {{rlid_pkg::CNT_OUT_W{1'b0}}, count};

  always_comb begin
    st.is_del   = op;
    st.full     = (count == CW'(DEPTH));
    st.empty    = (count == '0);
    st.one      = (count == CW'(1));
    st.idx_bad  = (idx_w >= cnt_w);
    st.idx_last = (idx_w == cnt_w - CMPW'(1));
    // insert reads down to position 1, delete reads up to the last entry
    st.last_rd  = op ? (ptr_w == cnt_w - CMPW'(1)) : (ptr_w == CMPW'(1));
  end

  // a pending shift write has priority, the controller never overlaps them
  always_comb begin
    we    = pend | ctl.write_value;
    waddr = pend ? dest : (count == '0 ? '0 : AW'(1));
    wdata = pend ? rdata : val;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      cap   <= 1'b0;
    end else begin
      pend <= ctl.rd & ctl.shift;
      cap  <= ctl.rd & ~ctl.shift;
      if (ctl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (ctl.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= command;
      val <= value;
      idx <= index;
    end
    if (ctl.ptr_ins) begin
      ptr <= AW'(count - CW'(1));
    end else if (ctl.ptr_del) begin
      ptr <= idx[AW-1:0];
    end else if (ctl.rd) begin
      ptr <= op ? ptr + AW'(1) : ptr - AW'(1);
    end
    if (ctl.rd) begin
      dest <= op ? ptr - AW'(1) : ptr + AW'(1);
    end
    if (ctl.load) begin
      removed <= '0;
    end else if (cap) begin
      removed <= rdata;
    end
    if (ctl.load) begin
      res_status <= rlid_pkg::ST_OK;
    end else if (ctl.set_status) begin
      res_status <= ctl.code;
    end
    if (ctl.out_load) begin
      removed_value <= removed;
      status        <= res_status;
      entry_count   <= cnt_ext[rlid_pkg::CNT_OUT_W-1:0];
    end
  end

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(pend && ctl.write_value))
    else $error("shift write and value write in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_dec |-> (count != '0))
    else $error("entry count decremented at zero");

endmodule

/* hdl/rlid_ctrl.sv */
// controller state machine sequencing the memory shift for each command
`timescale 1ns / 1ps
module rlid_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rlid_pkg::stat_t st,
  output rlid_pkg::ctl_t  ctl
);

  rlid_pkg::state_t state;
  rlid_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlid_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.code   = rlid_pkg::ST_OK;
    in_ready   = (state == rlid_pkg::S_IDLE);
    case (state)
      rlid_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = rlid_pkg::S_DECIDE;
        end
      end
      rlid_pkg::S_DECIDE: begin
        if (!st.is_del) begin
          if (st.full) begin
            ctl.set_status = 1'b1;
            ctl.code       = rlid_pkg::ST_FULL;
            state_next     = rlid_pkg::S_FINISH;
          end else if (st.empty || st.one) begin
            // nothing to move, value goes to head or just after it
            ctl.write_value = 1'b1;
            ctl.cnt_inc     = 1'b1;
            state_next      = rlid_pkg::S_FINISH;
          end else begin
            ctl.ptr_ins = 1'b1;
            state_next  = rlid_pkg::S_SHIFT;
          end
        end else begin
          if (st.idx_bad) begin
            ctl.set_status = 1'b1;
            ctl.code       = rlid_pkg::ST_NOT_FOUND;
            state_next     = rlid_pkg::S_FINISH;
          end else begin
            ctl.ptr_del = 1'b1;
            state_next  = rlid_pkg::S_DEL_RD;
          end
        end
      end
      rlid_pkg::S_DEL_RD: begin
        // read of the removed entry, held in rdata and then captured into removed
        ctl.rd     = 1'b1;
        state_next = st.idx_last ? rlid_pkg::S_DRAIN : rlid_pkg::S_SHIFT;
      end
      rlid_pkg::S_SHIFT: begin
        ctl.rd    = 1'b1;
        ctl.shift = 1'b1;
        if (st.last_rd) begin
          state_next = rlid_pkg::S_DRAIN;
        end
      end
      rlid_pkg::S_DRAIN: begin
        if (st.is_del) begin
          ctl.cnt_dec = 1'b1;
          state_next  = rlid_pkg::S_FINISH;
        end else begin
          state_next = rlid_pkg::S_INS_WR;
        end
      end
      rlid_pkg::S_INS_WR: begin
        ctl.write_value = 1'b1;
        ctl.cnt_inc     = 1'b1;
        state_next      = rlid_pkg::S_FINISH;
      end
      rlid_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = rlid_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rlid_pkg::S_IDLE;
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_no_idle_read: assert property (@(posedge clk) disable iff (rst)
    (state == rlid_pkg::S_IDLE || state == rlid_pkg::S_FINISH) |-> !ctl.rd)
    else $error("memory read outside the shift sequence");

  a_ins_only: assert property (@(posedge clk) disable iff (rst)
    (state == rlid_pkg::S_INS_WR) |-> !st.is_del)
    else $error("value write reached on a delete");

endmodule

/* hdl/ring_list_insert_delete_core.sv */
// top level of the ring list insert/delete core
`timescale 1ns / 1ps
// Holds an ordered ring of up to DEPTH signed 32-bit values in one memory,
// position 0 being the head. An add puts the value at the head of an empty
// ring, otherwise just after the head; a delete removes the entry at index
// and returns it. One command is handled at a time: the later entries move
// one memory word per cycle through the single read and write port; full,
// not_found and the trivial adds move no entries. A new command is taken
// as soon as the previous result sits in the output register, even before
// it is taken.
module ring_list_insert_delete_core #(
  parameter int DEPTH = rlid_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic signed [rlid_pkg::VAL_W-1:0]  value,
  input  logic [rlid_pkg::IDX_W-1:0]         index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rlid_pkg::VAL_W-1:0]  removed_value,
  output logic [1:0]                         status,
  output logic [rlid_pkg::CNT_OUT_W-1:0]     entry_count
);

  rlid_pkg::ctl_t  ctl;
  rlid_pkg::stat_t st;

  rlid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  rlid_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .st            (st),
    .command       (command),
    .value         (value),
    .index         (index),
    .removed_value (removed_value),
    .status        (status),
    .entry_count   (entry_count)
  );

endmodule
